@@ rtl/bthq_pkg.sv @@
// Shared codes and field widths for the bounded two-class hash queue.
// Depends on nothing; the queue top level imports it.
`timescale 1ns / 1ps

package bthq_pkg;

	// Field widths of the request and result channels.
	localparam int HANDLE_BITS    = 64;
	localparam int NOW_BITS       = 32;
	localparam int LIMIT_BITS     = 11;
	localparam int COUNT_OUT_BITS = 12;

	// Reset value of the entry limit register.
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 11'd1024;

	// Request operation codes.
	localparam logic [1:0] MODE_PUSH_IN    = 2'd0;
	localparam logic [1:0] MODE_PUSH_RETRY = 2'd1;
	localparam logic [1:0] MODE_POP        = 2'd2;

	// Result status codes.
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	// Sequencer states, one-hot.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

endpackage

@@ rtl/bounded_two_class_hash_queue.sv @@
// Top level of the bounded two-class hash queue: retry and incoming FIFOs in
// on-chip memories sharing one entry limit. Depends on bthq_pkg.
`timescale 1ns / 1ps

// Usage:
// A request on the in_* channel (valid/stall) carries mode, hash_handle and
// now_time. Mode 0 appends to the incoming queue with its arrival time, mode 1
// appends to the retry queue, mode 2 pops the front entry (retry queue first).
// After a push, entries above the max_entries limit are dropped, retry entries
// oldest first, then incoming entries oldest first, and the count is reported.
// Every request gives exactly one result on the out_* channel (valid/stall).
// Each request occupies the block for its accept cycle, in which the memories
// are read at both queue heads, and its execute state, in which counts and
// heads are updated, a push is written and the result is loaded into the
// output register. A new request is taken only once the last one has left
// the execute state. While a result waits because out_stall is high, the next
// request is still accepted, but it holds in its execute cycle until the output
// register frees up.
// max_entries is written on the cfg_* channel (valid/ready) while idle.
// Reset empties both queues and sets the limit to 1024; memory contents are
// not cleared, since only written entries are ever read.
module bounded_two_class_hash_queue #(
	parameter int QUEUE_DEPTH = 1024,
	parameter int TIME_BITS   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Request channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        mode,
	input  logic [bthq_pkg::HANDLE_BITS-1:0]  hash_handle,
	input  logic [bthq_pkg::NOW_BITS-1:0]     now_time,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              status,
	output logic [bthq_pkg::HANDLE_BITS-1:0]  popped_handle,
	output logic                              has_time,
	output logic [bthq_pkg::NOW_BITS-1:0]     popped_time,
	output logic [bthq_pkg::COUNT_OUT_BITS-1:0] dropped_count,
	output logic [bthq_pkg::COUNT_OUT_BITS-1:0] total_size,
	// Configuration channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bthq_pkg::LIMIT_BITS-1:0]   cfg_data
);
	import bthq_pkg::*;

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = (CW + 1 > COUNT_OUT_BITS) ? CW + 1 : COUNT_OUT_BITS;
	localparam int TB = (TIME_BITS < NOW_BITS) ? TIME_BITS : NOW_BITS;
	localparam int MW = HANDLE_BITS + TB;
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	// Advances a queue index by a step of at most QUEUE_DEPTH, wrapping once.
	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
			input logic [CW-1:0] step);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(step);
		if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW+1)'(QUEUE_DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	// Control and queue pointer state.
	state_t                state_q;
	logic [LIMIT_BITS-1:0] max_q;
	logic [IW-1:0]         retry_head_q, inc_head_q;
	logic [CW-1:0]         retry_cnt_q, inc_cnt_q;

	// Captured request.
	logic [1:0]             mode_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [TB-1:0]          time_q;

	// Memories and their registered read data.
	logic [HANDLE_BITS-1:0] retry_mem [QUEUE_DEPTH];
	logic [MW-1:0]          inc_mem [QUEUE_DEPTH];
	logic [HANDLE_BITS-1:0] retry_rd_q;
	logic [MW-1:0]          inc_rd_q;

	// Output register.
	logic                      out_valid_q;
	logic                      status_q;
	logic [HANDLE_BITS-1:0]    popped_handle_q;
	logic                      has_time_q;
	logic [NOW_BITS-1:0]       popped_time_q;
	logic [COUNT_OUT_BITS-1:0] dropped_q;
	logic [COUNT_OUT_BITS-1:0] total_q;

	// Execute-cycle signals.
	logic                   in_take;
	logic                   exec_go;
	logic                   is_push_in, is_push_rt;
	logic                   pre_drop;
	logic [IW-1:0]          slot_in, slot_rt;
	logic [IW-1:0]          r_head1, i_head1, r_head_n, i_head_n;
	logic [CW-1:0]          r_cnt1, i_cnt1, r_cnt_n, i_cnt_n;
	logic [SW-1:0]          total1, excess, rest;
	logic [CW-1:0]          drop_r, drop_i;
	logic [SW-1:0]          total_n, dropped_n;
	logic                   status_n, has_time_n;
	logic [HANDLE_BITS-1:0] popped_handle_n;
	logic [NOW_BITS-1:0]    popped_time_n;

	// Handshakes: one request in execute at a time, output register frees the execute slot.
	assign in_take   = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign exec_go   = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);

	assign is_push_in = (mode_q == MODE_PUSH_IN);
	assign is_push_rt = (mode_q == MODE_PUSH_RETRY);

	// Push slots; a full queue writes over its oldest entry, which it drops.
	assign slot_in = wrap_add(inc_head_q, inc_cnt_q);
	assign slot_rt = wrap_add(retry_head_q, retry_cnt_q);

	// Next queue state and result for the captured request.
	always_comb begin
		pre_drop        = 1'b0;
		r_head1         = retry_head_q;
		i_head1         = inc_head_q;
		r_cnt1          = retry_cnt_q;
		i_cnt1          = inc_cnt_q;
		status_n        = STATUS_OK;
		has_time_n      = 1'b0;
		popped_handle_n = '0;
		popped_time_n   = '0;
		case (mode_q)
			MODE_PUSH_IN: begin
				if (inc_cnt_q == DEPTH_C) begin
					pre_drop = 1'b1;
					i_head1  = wrap_add(inc_head_q, ONE_C);
				end else begin
					i_cnt1 = inc_cnt_q + ONE_C;
				end
			end
			MODE_PUSH_RETRY: begin
				if (retry_cnt_q == DEPTH_C) begin
					pre_drop = 1'b1;
					r_head1  = wrap_add(retry_head_q, ONE_C);
				end else begin
					r_cnt1 = retry_cnt_q + ONE_C;
				end
			end
			MODE_POP: begin
				if (retry_cnt_q != '0) begin
					popped_handle_n = retry_rd_q;
					r_head1         = wrap_add(retry_head_q, ONE_C);
					r_cnt1          = retry_cnt_q - ONE_C;
				end else if (inc_cnt_q != '0) begin
					popped_handle_n = inc_rd_q[HANDLE_BITS-1:0];
					popped_time_n   = NOW_BITS'(inc_rd_q[MW-1:HANDLE_BITS]);
					has_time_n      = 1'b1;
					i_head1         = wrap_add(inc_head_q, ONE_C);
					i_cnt1          = inc_cnt_q - ONE_C;
				end else begin
					status_n = STATUS_EMPTY;
				end
			end
			default: begin
			end
		endcase
	end

	// Trim against the limit in one step: retry entries first, then incoming.
	always_comb begin
		total1 = SW'(r_cnt1) + SW'(i_cnt1);
		if ((is_push_in || is_push_rt) && (total1 > SW'(max_q))) begin
			excess = total1 - SW'(max_q);
		end else begin
			excess = '0;
		end
		drop_r   = (excess > SW'(r_cnt1)) ? r_cnt1 : excess[CW-1:0];
		rest     = excess - SW'(drop_r);
		drop_i   = rest[CW-1:0];
		r_cnt_n  = r_cnt1 - drop_r;
		i_cnt_n  = i_cnt1 - drop_i;
		r_head_n = wrap_add(r_head1, drop_r);
		i_head_n = wrap_add(i_head1, drop_i);
		total_n  = SW'(r_cnt_n) + SW'(i_cnt_n);
		dropped_n = excess + SW'(pre_drop);
	end

	// Sequencer, limit register and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			max_q        <= LIMIT_RESET;
			retry_head_q <= '0;
			inc_head_q   <= '0;
			retry_cnt_q  <= '0;
			inc_cnt_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q      <= ST_IDLE;
						retry_head_q <= r_head_n;
						inc_head_q   <= i_head_n;
						retry_cnt_q  <= r_cnt_n;
						inc_cnt_q    <= i_cnt_n;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_q   <= mode;
			handle_q <= hash_handle;
			time_q   <= now_time[TB-1:0];
		end
	end

	// Memories: heads are read every cycle, pushes write in the execute cycle.
	always_ff @(posedge clk) begin
		retry_rd_q <= retry_mem[retry_head_q];
		inc_rd_q   <= inc_mem[inc_head_q];
		if (exec_go && is_push_rt) begin
			retry_mem[slot_rt] <= handle_q;
		end
		if (exec_go && is_push_in) begin
			inc_mem[slot_in] <= {time_q, handle_q};
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (exec_go) begin
			status_q        <= status_n;
			popped_handle_q <= popped_handle_n;
			has_time_q      <= has_time_n;
			popped_time_q   <= popped_time_n;
			dropped_q       <= dropped_n[COUNT_OUT_BITS-1:0];
			total_q         <= total_n[COUNT_OUT_BITS-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign popped_handle = popped_handle_q;
	assign has_time      = has_time_q;
	assign popped_time   = popped_time_q;
	assign dropped_count = dropped_q;
	assign total_size    = total_q;

`ifndef SYNTHESIS
	// Neither queue ever holds more than its memory depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(retry_cnt_q <= DEPTH_C) && (inc_cnt_q <= DEPTH_C))
		else $error("queue count above depth");

	// A finished push leaves the total within the limit.
	a_trim_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_go && (is_push_in || is_push_rt)) |-> (total_n <= SW'(max_q)))
		else $error("push left total above limit");

	// An accepted request is in the execute state in the following cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_EXEC))
		else $error("accepted request not in execute");

	// An empty pop reports empty queues and carries no entry.
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == STATUS_EMPTY)) |->
		((total_q == '0) && !has_time_q && (popped_handle_q == '0)))
		else $error("empty pop result inconsistent");
`endif

endmodule

@@ sim/tb_bounded_two_class_hash_queue.sv @@
// Self-checking testbench for the bounded two-class hash queue: drives push and pop
// requests with random idling on both channels and checks every result against a
// queue-based prediction. Depends on bthq_pkg and the bounded_two_class_hash_queue RTL.
`timescale 1ns / 1ps

module tb_bounded_two_class_hash_queue;
	import bthq_pkg::*;

	localparam int          Q_DEPTH     = 1024;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          HOLD_CYCLES = 400;
	// The fourth mode code is unused by the block and must act as a no-op.
	localparam logic [1:0]  MODE_NOP    = 2'd3;

	// One stored incoming entry.
	typedef struct packed {
		logic [HANDLE_BITS-1:0] handle;
		logic [NOW_BITS-1:0]    stamp;
	} arrival_t;

	// One predicted result.
	typedef struct packed {
		logic                      status;
		logic [HANDLE_BITS-1:0]    handle;
		logic                      has_time;
		logic [NOW_BITS-1:0]       stamp;
		logic [COUNT_OUT_BITS-1:0] dropped;
		logic [COUNT_OUT_BITS-1:0] total;
	} queue_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [1:0]                mode;
	logic [HANDLE_BITS-1:0]    hash_handle;
	logic [NOW_BITS-1:0]       now_time;
	logic                      out_valid;
	logic                      out_stall;
	logic                      status;
	logic [HANDLE_BITS-1:0]    popped_handle;
	logic                      has_time;
	logic [NOW_BITS-1:0]       popped_time;
	logic [COUNT_OUT_BITS-1:0] dropped_count;
	logic [COUNT_OUT_BITS-1:0] total_size;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [LIMIT_BITS-1:0]     cfg_data;

	// Prediction state: both queues and the entry bound.
	logic [HANDLE_BITS-1:0] retry_model[$];
	arrival_t               incoming_model[$];
	int                     entry_bound;
	queue_result_t          expected_results[$];

	int mismatches;
	int results_seen;
	int cycle_count;
	int burst_left;
	bit steady_sender;
	bit hold_start;
	int hold_left;
	int stall_style;
	int stall_phase_left;

	bounded_two_class_hash_queue u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.hash_handle  (hash_handle),
		.now_time     (now_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.popped_handle(popped_handle),
		.has_time     (has_time),
		.popped_time  (popped_time),
		.dropped_count(dropped_count),
		.total_size   (total_size),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// Drop entries above the bound: retry entries first, then incoming, oldest first.
	function automatic int trim_to_bound();
		int n;
		n = 0;
		while (retry_model.size() + incoming_model.size() > entry_bound) begin
			if (retry_model.size() > 0)
				retry_model.delete(0);
			else
				incoming_model.delete(0);
			n++;
		end
		return n;
	endfunction

	// Apply one accepted request to the queues and record the result it must give.
	function automatic void predict_queue_step(input logic [1:0] op,
			input logic [HANDLE_BITS-1:0] hnd, input logic [NOW_BITS-1:0] tm);
		queue_result_t r;
		arrival_t      a;
		int            dropped;
		r = '0;
		dropped = 0;
		case (op)
			MODE_PUSH_IN: begin
				if (incoming_model.size() >= Q_DEPTH) begin
					incoming_model.delete(0);
					dropped++;
				end
				a.handle = hnd;
				a.stamp  = tm;
				incoming_model.push_back(a);
				dropped += trim_to_bound();
			end
			MODE_PUSH_RETRY: begin
				if (retry_model.size() >= Q_DEPTH) begin
					retry_model.delete(0);
					dropped++;
				end
				retry_model.push_back(hnd);
				dropped += trim_to_bound();
			end
			MODE_POP: begin
				if (retry_model.size() > 0) begin
					r.handle = retry_model[0];
					retry_model.delete(0);
				end else if (incoming_model.size() > 0) begin
					a = incoming_model[0];
					incoming_model.delete(0);
					r.handle   = a.handle;
					r.stamp    = a.stamp;
					r.has_time = 1'b1;
				end else begin
					r.status = STATUS_EMPTY;
				end
			end
			default: ;
		endcase
		r.dropped = COUNT_OUT_BITS'(dropped);
		r.total   = COUNT_OUT_BITS'(retry_model.size() + incoming_model.size());
		expected_results.push_back(r);
	endfunction

	function automatic logic [HANDLE_BITS-1:0] rand_handle();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return HANDLE_BITS'($urandom_range(0, 15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [NOW_BITS-1:0] rand_stamp();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Offer one request and hold it until accepted. Called and returns at a falling edge.
	task automatic send_request(input logic [1:0] op, input logic [HANDLE_BITS-1:0] hnd,
			input logic [NOW_BITS-1:0] tm);
		int gap;
		in_valid    <= 1'b1;
		mode        <= op;
		hash_handle <= hnd;
		now_time    <= tm;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_queue_step(op, hnd, tm);
		@(negedge clk);
		if (steady_sender || burst_left > 0) begin
			if (burst_left > 0)
				burst_left--;
		end else begin
			// End of a burst: idle before the next one.
			in_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
		end
	endtask

	// Stop offering and wait until every predicted result has come back.
	task automatic wait_drained();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		while (expected_results.size() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write the entry bound while the block is idle.
	task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		entry_bound = int'(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Empty pops, extreme handles and times, retry-first pop order, the unused mode.
	task automatic test_basic_order();
		write_limit(LIMIT_RESET);
		send_request(MODE_POP, '1, '1);
		send_request(MODE_PUSH_IN, '1, '1);
		send_request(MODE_PUSH_IN, '0, '0);
		send_request(MODE_PUSH_RETRY, '1, '1);
		send_request(MODE_PUSH_RETRY, '0, '0);
		send_request(MODE_NOP, '1, '1);
		repeat (5) send_request(MODE_POP, '0, '0);
	endtask

	// Zero bound, retry-first trimming, and a lowered bound trimming many at once.
	task automatic test_limit_trim();
		write_limit('0);
		send_request(MODE_PUSH_IN, 64'h0123_4567_89ab_cdef, 32'h8000_0001);
		send_request(MODE_PUSH_RETRY, 64'hfedc_ba98_7654_3210, '0);
		send_request(MODE_POP, '0, '0);
		write_limit(11'd3);
		send_request(MODE_PUSH_RETRY, 64'h11, 32'h1);
		send_request(MODE_PUSH_RETRY, 64'h22, 32'h2);
		send_request(MODE_PUSH_IN, 64'h33, 32'h3);
		send_request(MODE_PUSH_IN, 64'h44, 32'h4);
		send_request(MODE_PUSH_IN, 64'h55, 32'h5);
		write_limit(11'd1);
		send_request(MODE_PUSH_RETRY, 64'h66, 32'h6);
		send_request(MODE_POP, '0, '0);
		send_request(MODE_POP, '0, '0);
	endtask

	// Random mix of all modes under one bound.
	task automatic test_random_mix(input logic [LIMIT_BITS-1:0] bound, input int count);
		int pick;
		logic [1:0] op;
		write_limit(bound);
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 42)
				op = MODE_PUSH_IN;
			else if (pick < 72)
				op = MODE_PUSH_RETRY;
			else if (pick < 97)
				op = MODE_POP;
			else
				op = MODE_NOP;
			send_request(op, rand_handle(), rand_stamp());
		end
	endtask

	// Hold the result channel off for a long stretch while requests keep coming.
	task automatic test_output_holdoff();
		write_limit(11'd16);
		steady_sender = 1'b1;
		hold_start = 1'b1;
		for (int i = 0; i < 12; i++)
			send_request(($urandom_range(0, 2) == 0) ? MODE_POP : MODE_PUSH_IN,
				rand_handle(), rand_stamp());
		steady_sender = 1'b0;
	endtask

	// Let the block run dry in the middle of a stream, then go on.
	task automatic test_drain_pause();
		for (int i = 0; i < 6; i++)
			send_request(MODE_PUSH_RETRY, rand_handle(), rand_stamp());
		wait_drained();
		for (int i = 0; i < 6; i++)
			send_request(($urandom_range(0, 1) == 0) ? MODE_POP : MODE_PUSH_IN,
				rand_handle(), rand_stamp());
	endtask

	// Fill the incoming queue past its depth, then trim it down with a bound of four.
	task automatic test_full_queue();
		int in_pushes;
		in_pushes = 0;
		write_limit('1);
		while (in_pushes < Q_DEPTH + 4) begin
			if ($urandom_range(0, 63) == 0) begin
				send_request(MODE_PUSH_RETRY, rand_handle(), rand_stamp());
			end else begin
				send_request(MODE_PUSH_IN, {$urandom, $urandom}, $urandom);
				in_pushes++;
			end
		end
		write_limit(11'd4);
		send_request(MODE_PUSH_RETRY, rand_handle(), rand_stamp());
		repeat (6) send_request(MODE_POP, '0, '0);
		write_limit(LIMIT_RESET);
	endtask

	// Result checker: every accepted result against the oldest prediction.
	task automatic check_field(input string name, input logic [HANDLE_BITS-1:0] want,
			input logic [HANDLE_BITS-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %0h, got %0h", results_seen, name,
					want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		queue_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with no request outstanding", results_seen);
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				check_field("status", HANDLE_BITS'(want.status), HANDLE_BITS'(status));
				check_field("popped_handle", want.handle, popped_handle);
				check_field("has_time", HANDLE_BITS'(want.has_time), HANDLE_BITS'(has_time));
				check_field("popped_time", HANDLE_BITS'(want.stamp), HANDLE_BITS'(popped_time));
				check_field("dropped_count", HANDLE_BITS'(want.dropped),
					HANDLE_BITS'(dropped_count));
				check_field("total_size", HANDLE_BITS'(want.total), HANDLE_BITS'(total_size));
			end
			results_seen++;
		end
	end

	// Receiver stall: a long hold-off on request, otherwise phases of varying pressure.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_start) begin
			hold_start = 1'b0;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			if (stall_phase_left == 0) begin
				stall_style = $urandom_range(0, 3);
				stall_phase_left = $urandom_range(20, 120);
			end
			stall_phase_left--;
			case (stall_style)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= stall_phase_left[2];
			endcase
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("bounded_two_class_hash_queue: mismatch");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_PUSH_IN;
		hash_handle = '0;
		now_time = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		entry_bound = int'(LIMIT_RESET);
		mismatches = 0;
		results_seen = 0;
		cycle_count = 0;
		burst_left = 0;
		steady_sender = 1'b0;
		hold_start = 1'b0;
		hold_left = 0;
		stall_style = 0;
		stall_phase_left = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_order();
		test_limit_trim();
		test_random_mix(LIMIT_RESET, 16);
		test_random_mix(11'($urandom_range(1, 8)), 16);
		test_random_mix('0, 8);
		test_random_mix(11'($urandom_range(9, 64)), 12);
		test_output_holdoff();
		test_drain_pause();
		test_full_queue();

		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("bounded_two_class_hash_queue: match");
		else
			$display("bounded_two_class_hash_queue: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
rtl/bthq_pkg.sv
rtl/bounded_two_class_hash_queue.sv
sim/tb_bounded_two_class_hash_queue.sv
